/* hdl/pte_pkg.sv */
package pte_pkg;

    localparam int RING_DEPTH_DEF    = 32;
    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int EJECTOR_COUNT_DEF = 2;

    localparam logic [1:0] REQ_TRIGGER = 2'd0;
    localparam logic [1:0] REQ_LATCH   = 2'd1;
    localparam logic [1:0] REQ_ACTION  = 2'd2;
    localparam logic [1:0] REQ_SERVICE = 2'd3;

    localparam logic [1:0] KIND_EJECT = 2'd0;
    localparam logic [1:0] KIND_PAUSE = 2'd1;
    localparam logic [1:0] KIND_FAULT = 2'd2;

    localparam logic [1:0] FAULT_BAD_EJECTOR = 2'd0;
    localparam logic [1:0] FAULT_UNPAIRED    = 2'd1;
    localparam logic [1:0] FAULT_STALE       = 2'd2;
    localparam logic [1:0] FAULT_OVERFLOW    = 2'd3;

    localparam logic CFG_DISTANCE_0 = 1'b0;
    localparam logic CFG_DISTANCE_1 = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] position;
        logic [7:0]  ej_num;
        logic [31:0] part_no;
        logic [31:0] offset;
        logic        action;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ejector;
        logic [31:0] part_number;
        logic [1:0]  fault_code;
        logic        last;
    } rsp_t;

    function automatic logic reached(input logic [31:0] now, input logic [31:0] target);
        logic [31:0] d;
        d = now - target;
        return ~d[31];
    endfunction

endpackage

/* hdl/pte_req_if.sv */
interface pte_req_if;
    logic          valid;
    logic          ready;
    pte_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/pte_rsp_if.sv */
interface pte_rsp_if;
    logic          valid;
    logic          ready;
    pte_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/pte_ram.sv */
module pte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/position_tracked_ejection_scheduler_unit.sv */
// Ejection scheduler. Each request is a camera trigger, a part latch, an action or a
// service tick. Trigger and latch are handled on acceptance, as is an action that fails
// the ejector or pairing check; a paired action goes through a ring read, then target add
// and queue check. A service tick reads and checks each ejector's queue head in turn,
// reading the queue memory again after every fired command, and sends the final one
// when anything fired; each fired command is held one step so that the final one can
// be marked, and a command waits while the output register is still occupied. Results
// sit in an output register; the next request is taken once that register is free.
// Ring tags and snapshots share one memory, the queues of all ejectors another; ring
// slots carry valid bits that reset clears. No clearing pass.
module position_tracked_ejection_scheduler_unit #(
    parameter int RING_DEPTH    = pte_pkg::RING_DEPTH_DEF,
    parameter int QUEUE_DEPTH   = pte_pkg::QUEUE_DEPTH_DEF,
    parameter int EJECTOR_COUNT = pte_pkg::EJECTOR_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    pte_req_if.sink     req,
    pte_rsp_if.source   rsp
);
    localparam int RW = $clog2(RING_DEPTH);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int EW = (EJECTOR_COUNT > 1) ? $clog2(EJECTOR_COUNT) : 1;
    localparam int QAW = EW + QW;
    localparam int QDEPTH_ALL = (1 << EW) * (1 << QW);
    localparam int RDEPTH_ALL = 1 << RW;
    localparam logic [QW-1:0] QLAST = QW'(QUEUE_DEPTH - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RREAD  = 3'd1;
    localparam logic [2:0] ST_ACT    = 3'd2;
    localparam logic [2:0] ST_SREAD  = 3'd3;
    localparam logic [2:0] ST_SCHECK = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]  state_reg, state_next;
    pte_pkg::req_t cur_reg;
    logic [31:0] dist_reg [2];
    logic [31:0] count_reg;
    logic [31:0] lpart_reg;
    logic [7:0]  lej_reg;
    logic        lvalid_reg;
    logic [QW-1:0] head_reg [2];
    logic [QW-1:0] tail_reg [2];
    logic [RDEPTH_ALL-1:0] rvalid_reg;
    logic        sej_reg;
    logic        fired_reg;
    pte_pkg::rsp_t hold_reg;
    logic        outv_reg;
    pte_pkg::rsp_t out_reg;

    // ring memory: {position, tag}
    logic          r_we;
    logic [RW-1:0] r_waddr, r_raddr;
    logic [63:0]   r_wdata, r_rdata;
    pte_ram #(.WIDTH(64), .DEPTH(RDEPTH_ALL)) u_ring (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    // queue memory: {target, action, part}
    logic           q_we;
    logic [QAW-1:0] q_waddr, q_raddr;
    logic [64:0]    q_wdata, q_rdata;
    pte_ram #(.WIDTH(65), .DEPTH(QDEPTH_ALL)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    logic [31:0] count_inc;
    logic [RW-1:0] lslot;
    logic        aej;
    logic [31:0] target;
    logic [QW-1:0] tnext;
    logic [QW-1:0] hnext;
    logic        s_last_ej;
    logic        in_xfer, out_free;
    logic        a_bad, a_unpaired;
    logic        act_hit, act_late, act_full;
    logic        s_due;
    logic        out_load;
    pte_pkg::rsp_t fire_rsp;

    assign count_inc = count_reg + 32'd1;
    assign lslot     = lpart_reg[RW-1:0];
    assign aej       = cur_reg.ej_num[0];
    assign target    = r_rdata[63:32] + dist_reg[aej] + cur_reg.offset;
    assign tnext     = (tail_reg[aej] == QLAST) ? '0 : tail_reg[aej] + QW'(1);
    assign hnext     = (head_reg[sej_reg] == QLAST) ? '0 : head_reg[sej_reg] + QW'(1);
    assign s_last_ej = (EJECTOR_COUNT == 1) || sej_reg;
    assign out_free  = !outv_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign in_xfer   = req.valid && req.ready;
    assign rsp.valid = outv_reg;
    assign rsp.data  = out_reg;

    assign a_bad      = req.data.ej_num >= 8'(EJECTOR_COUNT);
    assign a_unpaired = !lvalid_reg || req.data.ej_num != lej_reg;
    assign act_hit    = rvalid_reg[lslot] && r_rdata[31:0] == lpart_reg;
    assign act_late   = pte_pkg::reached(cur_reg.position, target);
    assign act_full   = tnext == head_reg[aej];
    assign s_due      = head_reg[sej_reg] != tail_reg[sej_reg]
                        && pte_pkg::reached(cur_reg.position, q_rdata[64:33]);
    assign fire_rsp   = '{q_rdata[32] ? pte_pkg::KIND_PAUSE : pte_pkg::KIND_EJECT,
                          sej_reg, q_rdata[31:0], 2'd0, 1'b0};

    // memory addressing
    always_comb
    begin
        r_we    = 1'b0;
        r_waddr = count_inc[RW-1:0];
        r_wdata = {req.data.position, count_inc};
        r_raddr = lslot;
        q_we    = 1'b0;
        q_waddr = {EW'(aej), tail_reg[aej]};
        q_wdata = {target, cur_reg.action, lpart_reg};
        q_raddr = {EW'(sej_reg), head_reg[sej_reg]};
        if (in_xfer && req.data.req_type == pte_pkg::REQ_TRIGGER)
        begin
            r_we = 1'b1;
        end
        if (state_reg == ST_ACT && act_hit && !act_late && !act_full)
        begin
            q_we = 1'b1;
        end
    end

    // load the output register this cycle
    always_comb
    begin
        out_load = 1'b0;
        if (state_reg == ST_IDLE && in_xfer && req.data.req_type == pte_pkg::REQ_ACTION
            && (a_bad || a_unpaired))
        begin
            out_load = 1'b1;
        end
        if (state_reg == ST_ACT && !q_we)
        begin
            out_load = 1'b1;
        end
        if (state_reg == ST_SCHECK && s_due && fired_reg && out_free)
        begin
            out_load = 1'b1;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_load = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   state_next = ST_IDLE;
            ST_RREAD:  state_next = ST_ACT;
            ST_ACT:    state_next = ST_IDLE;
            ST_SREAD:  state_next = ST_SCHECK;
            ST_SCHECK: state_next = ST_SCHECK;
            ST_OUT:    state_next = ST_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cur_reg     <= '0;
            dist_reg[0] <= '0;
            dist_reg[1] <= '0;
            count_reg   <= '0;
            lpart_reg   <= '0;
            lej_reg     <= '0;
            lvalid_reg  <= 1'b0;
            head_reg[0] <= '0;
            head_reg[1] <= '0;
            tail_reg[0] <= '0;
            tail_reg[1] <= '0;
            rvalid_reg  <= '0;
            sej_reg     <= 1'b0;
            fired_reg   <= 1'b0;
            hold_reg    <= '0;
            outv_reg    <= 1'b0;
            out_reg     <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pte_pkg::CFG_DISTANCE_0: dist_reg[0] <= cfg_data;
                    pte_pkg::CFG_DISTANCE_1: dist_reg[1] <= cfg_data;
                    default: ;
                endcase
            end
            if (outv_reg && rsp.ready && !out_load)
            begin
                outv_reg <= 1'b0;
            end
            if (r_we)
            begin
                rvalid_reg[count_inc[RW-1:0]] <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        cur_reg <= req.data;
                        unique case (req.data.req_type)
                            pte_pkg::REQ_TRIGGER:
                            begin
                                count_reg <= count_inc;
                            end
                            pte_pkg::REQ_LATCH:
                            begin
                                if (req.data.part_no == '0)
                                begin
                                    head_reg[0] <= tail_reg[0];
                                    head_reg[1] <= tail_reg[1];
                                    lpart_reg   <= '0;
                                    lej_reg     <= '0;
                                    lvalid_reg  <= 1'b0;
                                    count_reg   <= '0;
                                end
                                else
                                begin
                                    lpart_reg  <= req.data.part_no;
                                    lej_reg    <= req.data.ej_num;
                                    lvalid_reg <= 1'b1;
                                end
                            end
                            pte_pkg::REQ_ACTION:
                            begin
                                if (a_bad)
                                begin
                                    out_reg  <= '{pte_pkg::KIND_FAULT, 1'b0, 32'd0,
                                                 pte_pkg::FAULT_BAD_EJECTOR, 1'b1};
                                    outv_reg <= 1'b1;
                                end
                                else if (a_unpaired)
                                begin
                                    out_reg  <= '{pte_pkg::KIND_FAULT, 1'b0, 32'd0,
                                                 pte_pkg::FAULT_UNPAIRED, 1'b1};
                                    outv_reg <= 1'b1;
                                end
                                else
                                begin
                                    lvalid_reg <= 1'b0;
                                    state_reg  <= ST_RREAD;
                                end
                            end
                            default:
                            begin
                                sej_reg   <= 1'b0;
                                fired_reg <= 1'b0;
                                state_reg <= ST_SREAD;
                            end
                        endcase
                    end
                end
                ST_RREAD:
                begin
                    state_reg <= state_next;
                end
                ST_ACT:
                begin
                    // check tag, staleness and room, then enqueue
                    if (!act_hit || act_late)
                    begin
                        out_reg  <= '{pte_pkg::KIND_FAULT, 1'b0, 32'd0,
                                     pte_pkg::FAULT_STALE, 1'b1};
                        outv_reg <= 1'b1;
                    end
                    else if (act_full)
                    begin
                        out_reg  <= '{pte_pkg::KIND_FAULT, 1'b0, 32'd0,
                                     pte_pkg::FAULT_OVERFLOW, 1'b1};
                        outv_reg <= 1'b1;
                    end
                    else
                    begin
                        tail_reg[aej] <= tnext;
                    end
                    state_reg <= state_next;
                end
                ST_SREAD:
                begin
                    state_reg <= state_next;
                end
                ST_SCHECK:
                begin
                    // hold the due head; send the previously held one onward
                    if (s_due)
                    begin
                        if (!fired_reg)
                        begin
                            hold_reg  <= fire_rsp;
                            fired_reg <= 1'b1;
                            head_reg[sej_reg] <= hnext;
                            state_reg <= ST_SREAD;
                        end
                        else if (out_free)
                        begin
                            out_reg   <= hold_reg;
                            outv_reg  <= 1'b1;
                            hold_reg  <= fire_rsp;
                            head_reg[sej_reg] <= hnext;
                            state_reg <= ST_SREAD;
                        end
                    end
                    else if (!s_last_ej)
                    begin
                        sej_reg   <= 1'b1;
                        state_reg <= ST_SREAD;
                    end
                    else if (fired_reg)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT:
                begin
                    // the held command is the final one: send it marked as last
                    if (out_free)
                    begin
                        out_reg   <= '{hold_reg.kind, hold_reg.ejector,
                                      hold_reg.part_number, hold_reg.fault_code, 1'b1};
                        outv_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

/* bench/pte_checker.sv */
`timescale 1ns / 100ps

module pte_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    pte_req_if          req,
    pte_rsp_if          rsp,
    output int          errors,
    output int          outstanding,
    output int          delivered
);

    localparam int RING_N  = pte_pkg::RING_DEPTH_DEF;
    localparam int QUEUE_N = pte_pkg::QUEUE_DEPTH_DEF;
    localparam int EJ_N    = pte_pkg::EJECTOR_COUNT_DEF;

    // Scheduler state as predicted from accepted transfers
    logic [31:0] ej_dist [EJ_N];
    logic [31:0] cam_count;
    logic [31:0] snap_pos [RING_N];
    logic [31:0] snap_tag [RING_N];
    logic [31:0] pend_part;
    logic [7:0]  pend_ej;
    logic        pend_valid;
    int          q_head [EJ_N];
    int          q_tail [EJ_N];
    logic [31:0] q_target [EJ_N][QUEUE_N];
    logic        q_pause [EJ_N][QUEUE_N];
    logic [31:0] q_part [EJ_N][QUEUE_N];

    pte_pkg::rsp_t expected_rsp [$];

    function automatic logic past_target(input logic [31:0] now, input logic [31:0] tgt);
        logic [31:0] diff;
        diff = now - tgt;
        return !diff[31];
    endfunction

    task automatic push_fault(input logic [1:0] code);
        pte_pkg::rsp_t o;
        o = '0;
        o.kind = pte_pkg::KIND_FAULT;
        o.fault_code = code;
        o.last = 1'b1;
        expected_rsp.push_back(o);
    endtask

    task automatic schedule(input pte_pkg::req_t r);
        logic [31:0]   c;
        logic [31:0]   tgt;
        int            slot;
        int            nxt;
        int            fired;
        int            h;
        pte_pkg::rsp_t o;
        case (r.req_type)
            pte_pkg::REQ_TRIGGER:
            begin
                c = cam_count + 1;
                slot = c % RING_N;
                snap_pos[slot] = r.position;
                snap_tag[slot] = c;
                cam_count = c;
            end
            pte_pkg::REQ_LATCH:
            begin
                if (r.part_no == 0)
                begin
                    // flush every queue and forget the pending part
                    for (int e = 0; e < EJ_N; e++)
                        q_head[e] = q_tail[e];
                    pend_part = '0;
                    pend_ej = '0;
                    pend_valid = 1'b0;
                    cam_count = '0;
                end
                else
                begin
                    pend_part = r.part_no;
                    pend_ej = r.ej_num;
                    pend_valid = 1'b1;
                end
            end
            pte_pkg::REQ_ACTION:
            begin
                if (r.ej_num >= EJ_N)
                    push_fault(pte_pkg::FAULT_BAD_EJECTOR);
                else if (!pend_valid || r.ej_num != pend_ej)
                    push_fault(pte_pkg::FAULT_UNPAIRED);
                else
                begin
                    // consume the latch, then pair with the ring snapshot
                    pend_valid = 1'b0;
                    slot = pend_part % RING_N;
                    if (snap_tag[slot] != pend_part)
                        push_fault(pte_pkg::FAULT_STALE);
                    else
                    begin
                        tgt = snap_pos[slot] + ej_dist[r.ej_num] + r.offset;
                        nxt = (q_tail[r.ej_num] + 1) % QUEUE_N;
                        if (past_target(r.position, tgt))
                            push_fault(pte_pkg::FAULT_STALE);
                        else if (nxt == q_head[r.ej_num])
                            push_fault(pte_pkg::FAULT_OVERFLOW);
                        else
                        begin
                            q_target[r.ej_num][q_tail[r.ej_num]] = tgt;
                            q_pause[r.ej_num][q_tail[r.ej_num]] = r.action;
                            q_part[r.ej_num][q_tail[r.ej_num]] = pend_part;
                            q_tail[r.ej_num] = nxt;
                        end
                    end
                end
            end
            default:
            begin
                // drain ejector 0 first, then ejector 1
                fired = 0;
                for (int e = 0; e < EJ_N; e++)
                begin
                    while (q_head[e] != q_tail[e]
                           && past_target(r.position, q_target[e][q_head[e]]))
                    begin
                        h = q_head[e];
                        o = '0;
                        o.kind = q_pause[e][h] ? pte_pkg::KIND_PAUSE : pte_pkg::KIND_EJECT;
                        o.ejector = e[0];
                        o.part_number = q_part[e][h];
                        expected_rsp.push_back(o);
                        fired++;
                        q_head[e] = (h + 1) % QUEUE_N;
                    end
                end
                if (fired > 0)
                begin
                    o = expected_rsp.pop_back();
                    o.last = 1'b1;
                    expected_rsp.push_back(o);
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pte_pkg::rsp_t want;
        if (!rst_n)
        begin
            ej_dist[0] = '0;
            ej_dist[1] = '0;
            cam_count = '0;
            for (int i = 0; i < RING_N; i++)
                snap_tag[i] = '0;
            pend_part = '0;
            pend_ej = '0;
            pend_valid = 1'b0;
            for (int e = 0; e < EJ_N; e++)
            begin
                q_head[e] = 0;
                q_tail[e] = 0;
            end
            expected_rsp.delete();
            errors = 0;
            delivered = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == pte_pkg::CFG_DISTANCE_0)
                    ej_dist[0] = cfg_data;
                else
                    ej_dist[1] = cfg_data;
            end
            // compare the result transfer with the oldest expectation
            if (rsp.valid && rsp.ready)
            begin
                delivered++;
                if (expected_rsp.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, rsp.data);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.data.kind !== want.kind || rsp.data.ejector !== want.ejector
                        || rsp.data.part_number !== want.part_number
                        || rsp.data.fault_code !== want.fault_code
                        || rsp.data.last !== want.last)
                    begin
                        errors++;
                        $display("%0t: expected %p, actual %p", $time, want, rsp.data);
                    end
                end
            end
            if (req.valid && req.ready)
                schedule(req.data);
        end
        outstanding = expected_rsp.size();
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    bit          quiet;
    int          errors;
    int          outstanding;
    int          delivered;
    int          sent;
    int          trig_count;
    logic [31:0] motor;

    pte_req_if req ();
    pte_rsp_if rsp ();

    position_tracked_ejection_scheduler_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    pte_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req         (req),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding),
        .delivered   (delivered)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Stall the result side at random unless in a quiet stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= quiet || ($urandom_range(99) >= 18);
    end

    initial
    begin
        #5ms;
        $display("position_tracked_ejection_scheduler_unit: mismatch");
        $finish;
    end

    function automatic pte_pkg::req_t noise_req();
        pte_pkg::req_t r;
        r.req_type = 2'($urandom_range(3));
        r.position = $urandom;
        r.ej_num = 8'($urandom);
        r.part_no = $urandom;
        r.offset = $urandom;
        r.action = 1'($urandom);
        return r;
    endfunction

    task automatic send(input pte_pkg::req_t r);
        if (!quiet)
        begin
            while ($urandom_range(99) < 18)
            begin
                req.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req.valid <= 1'b1;
        req.data <= r;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sent++;
        // track the trigger count so latches can name real parts
        if (r.req_type == pte_pkg::REQ_TRIGGER)
            trig_count++;
        else if (r.req_type == pte_pkg::REQ_LATCH && r.part_no == 0)
            trig_count = 0;
    endtask

    task automatic trigger();
        pte_pkg::req_t r;
        r = noise_req();
        r.req_type = pte_pkg::REQ_TRIGGER;
        r.position = motor;
        send(r);
        motor = motor + $urandom_range(1, 40);
    endtask

    task automatic latch(input logic [31:0] part, input logic [7:0] ej);
        pte_pkg::req_t r;
        r = noise_req();
        r.req_type = pte_pkg::REQ_LATCH;
        r.part_no = part;
        r.ej_num = ej;
        send(r);
    endtask

    task automatic act(input logic [7:0] ej, input logic [31:0] off, input logic pause);
        pte_pkg::req_t r;
        r = noise_req();
        r.req_type = pte_pkg::REQ_ACTION;
        r.position = motor;
        r.ej_num = ej;
        r.offset = off;
        r.action = pause;
        send(r);
    endtask

    task automatic service(input logic [31:0] step);
        pte_pkg::req_t r;
        r = noise_req();
        r.req_type = pte_pkg::REQ_SERVICE;
        motor = motor + step;
        r.position = motor;
        send(r);
    endtask

    // Hold the sender until every result is back, then let the block settle
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic set_distances(input logic [31:0] d0, input logic [31:0] d1);
        cfg_we <= 1'b1;
        cfg_index <= pte_pkg::CFG_DISTANCE_0;
        cfg_data <= d0;
        @(posedge clk);
        cfg_index <= pte_pkg::CFG_DISTANCE_1;
        cfg_data <= d1;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Well-formed trigger, latch, action and service flow with random content
    task automatic part_flow();
        logic [7:0]  ej;
        logic [31:0] part;
        trigger();
        if ($urandom_range(1))
            trigger();
        part = trig_count - $urandom_range(0, trig_count > 2 ? 2 : trig_count - 1);
        ej = 8'($urandom_range(1));
        latch(part, ej);
        act(ej, $urandom_range(100, 3000), 1'($urandom));
        repeat ($urandom_range(0, 2))
            service($urandom_range(0, 500));
    endtask

    task automatic random_phase(input int count);
        int target_sent;
        int pick;
        target_sent = sent + count;
        while (sent < target_sent)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                part_flow();
            else if (pick < 82)
                service($urandom_range(0, 2000));
            else if (pick < 98)
                send(noise_req());
            else
                latch('0, 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = pte_pkg::CFG_DISTANCE_0;
        cfg_data = '0;
        req.valid = 1'b0;
        req.data = '0;
        quiet = 1'b0;
        sent = 0;
        trig_count = 0;
        motor = 32'h1000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: faults, extremes and one fired command of each kind
        set_distances(32'd500, 32'd800);
        act(8'd0, 32'd0, 1'b0);
        act(8'd255, 32'd0, 1'b0);
        trigger();
        latch(trig_count, 8'd1);
        act(8'd0, 32'd100, 1'b0);
        act(8'd1, 32'd100, 1'b1);
        latch(32'hFFFF_FFFF, 8'd0);
        act(8'd0, 32'd100, 1'b0);
        trigger();
        latch(trig_count, 8'd0);
        act(8'd0, 32'h8000_0000, 1'b0);
        trigger();
        latch(trig_count, 8'd0);
        act(8'd0, 32'h7FFF_FFFF, 1'b0);
        trigger();
        latch(trig_count, 8'd0);
        act(8'd0, 32'd50, 1'b0);
        service(32'd0);
        service(32'd5000);
        latch(trig_count, 8'hFF);
        act(8'd1, 32'd0, 1'b0);
        latch('0, 8'd0);
        drain();

        // Fill ejector 0 past capacity, then fire the whole queue at once
        repeat (16)
        begin
            trigger();
            latch(trig_count, 8'd0);
            act(8'd0, 32'd4000, 1'($urandom));
        end
        service(32'd100000);
        drain();

        random_phase(110);
        drain();

        // Extreme distances, no idling on either side
        quiet = 1'b1;
        set_distances(32'h8000_0000, 32'h7FFF_FFFF);
        random_phase(100);
        drain();
        quiet = 1'b0;

        set_distances($urandom_range(0, 2000), $urandom_range(0, 2000));
        random_phase(110);
        drain();

        set_distances('0, 32'hFFFF_FF00);
        random_phase(60);
        drain();

        $display("Covered %0d requests (faults, overflow, flush, distance extremes);",
                 sent);
        $display("%0d results checked.", delivered);
        if (errors == 0)
            $display("position_tracked_ejection_scheduler_unit: match");
        else
            $display("position_tracked_ejection_scheduler_unit: mismatch");
        $finish;
    end

endmodule

/* sim.f */
hdl/pte_pkg.sv
hdl/pte_req_if.sv
hdl/pte_rsp_if.sv
hdl/pte_ram.sv
hdl/position_tracked_ejection_scheduler_unit.sv
bench/pte_checker.sv
bench/tb.sv
